### sv/filtered_pid_with_dd_term_macros.svh
// Assertion macros for the filtered PID block.
`ifndef FILTERED_PID_WITH_DD_TERM_MACROS_SVH
`define FILTERED_PID_WITH_DD_TERM_MACROS_SVH

// same-cycle implication, checked out of reset
`define FPID_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FPID_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/fpid_pkg.sv
// Constants shared by the filtered PID block.
`default_nettype none
package fpid_pkg;
    // smoothing coefficients 1/(1+tc) in Q0.16
    localparam int ALPHA_MEAS  = 64887;
    localparam int ALPHA_RATE  = 59578;
    localparam int ALPHA_SHIFT = 16;
    localparam int ALPHA_BITS  = 18;

    // configuration register indexes
    localparam logic [2:0] REG_GAIN_PROP   = 3'd0;
    localparam logic [2:0] REG_GAIN_INT    = 3'd1;
    localparam logic [2:0] REG_GAIN_DERIV  = 3'd2;
    localparam logic [2:0] REG_GAIN_DDERIV = 3'd3;
    localparam logic [2:0] REG_MODE        = 3'd4;
    localparam logic [2:0] REG_OUTPUT_MAX  = 3'd5;
    localparam logic [2:0] REG_ERROR_LIMIT = 3'd6;
    localparam logic [2:0] REG_RATE_LIMIT  = 3'd7;
endpackage
`default_nettype wire

### sv/fpid_mul.sv
// Shared signed multiplier with registered product.
`default_nettype none
module fpid_mul #(
    parameter int AW = 29,
    parameter int BW = 24
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic signed [AW-1:0]     a,
    input  wire logic signed [BW-1:0]     b,
    output logic signed [AW+BW-1:0]       prod
);
    logic signed [AW+BW-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= (AW+BW)'(a) * (AW+BW)'(b);
        end
    end

    assign prod = prod_reg;
endmodule
`default_nettype wire

### sv/filtered_pid_with_dd_term.sv
// Filtered PID controller with second-derivative term, one shared multiplier.
//
//  port group   dir  payload (low bits first)
//  s_*          in   setpoint, measurement, error_in, rate_in
//  m_*          out  drive, p_term, i_term, d_term, dd_term
//  cfg_*        in   register write: index, data
//
// Each accepted beat runs through 18 sequencer steps, seven of them
// multiplies on the single shared multiplier (operand, then registered product).
// s_tready is high only while the sequencer is idle. The result sits in an
// output register; a stalled m side holds the sequencer at its last step only.
// Reset clears all filter and integrator state and the configuration registers.
`default_nettype none
`include "filtered_pid_with_dd_term_macros.svh"
module filtered_pid_with_dd_term
    import fpid_pkg::*;
#(
    parameter int WORD_WIDTH    = 24,
    parameter int FRAC_BITS     = 12,
    parameter int PROP_LIMIT_Q8 = 256,
    parameter int INT_LIMIT_Q8  = 128,
    parameter int DEV_LIMIT_Q8  = 256,
    parameter int DDEV_LIMIT_Q8 = 256,
    localparam int IN_BITS  = ((4*WORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_BITS = ((5*WORD_WIDTH + 7) / 8) * 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // setpoint, measurement, error_in, rate_in
    input  wire logic [IN_BITS-1:0]    s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // drive, p_term, i_term, d_term, dd_term
    output logic [OUT_BITS-1:0]        m_tdata,
    input  wire logic                  cfg_we,
    input  wire logic [2:0]            cfg_addr,
    input  wire logic [WORD_WIDTH-1:0] cfg_data
);
    localparam int W  = WORD_WIDTH;
    localparam int SW = W + 4;                      // filter state width
    localparam int AW = SW + 1;                     // multiplier operand a
    localparam int BW = (W > ALPHA_BITS) ? W : ALPHA_BITS;
    localparam int PW = AW + BW;
    localparam int LW = W + 9;                      // term limit width

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_M1   = 5'd1;
    localparam logic [4:0] S_M2   = 5'd2;
    localparam logic [4:0] S_E    = 5'd3;
    localparam logic [4:0] S_R0   = 5'd4;
    localparam logic [4:0] S_R1   = 5'd5;
    localparam logic [4:0] S_R2   = 5'd6;
    localparam logic [4:0] S_A0   = 5'd7;
    localparam logic [4:0] S_A1   = 5'd8;
    localparam logic [4:0] S_A2   = 5'd9;
    localparam logic [4:0] S_P1   = 5'd10;
    localparam logic [4:0] S_P2   = 5'd11;
    localparam logic [4:0] S_I1   = 5'd12;
    localparam logic [4:0] S_I2   = 5'd13;
    localparam logic [4:0] S_D1   = 5'd14;
    localparam logic [4:0] S_D2   = 5'd15;
    localparam logic [4:0] S_DD1  = 5'd16;
    localparam logic [4:0] S_DD2  = 5'd17;
    localparam logic [4:0] S_SUM  = 5'd18;

    function automatic logic signed [PW-1:0] clamp_lim(
        input logic signed [PW-1:0] v,
        input logic [LW-1:0]        m
    );
        logic signed [PW-1:0] ms;
        logic signed [PW-1:0] r;
        ms = $signed({{(PW-LW){1'b0}}, m});
        r  = v;
        if (m != '0)
        begin
            if (v > ms)
                r = ms;
            else if (v < -ms)
                r = -ms;
        end
        return r;
    endfunction

    function automatic logic signed [W-1:0] sat_w(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] hi;
        logic signed [PW-1:0] lo;
        logic signed [W-1:0]  r;
        hi = $signed({{(PW-W+1){1'b0}}, {(W-1){1'b1}}});
        lo = -hi - PW'(1);
        if (v > hi)
            r = W'(hi);
        else if (v < lo)
            r = W'(lo);
        else
            r = W'(v);
        return r;
    endfunction

    // configuration
    logic signed [W-1:0] gain_p_reg, gain_i_reg, gain_d_reg, gain_dd_reg;
    logic [1:0]          mode_reg;
    logic [W-2:0]        omax_reg, elim_reg, rlim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg  <= '0;
            gain_i_reg  <= '0;
            gain_d_reg  <= '0;
            gain_dd_reg <= '0;
            mode_reg    <= '0;
            omax_reg    <= '0;
            elim_reg    <= '0;
            rlim_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_GAIN_PROP:   gain_p_reg  <= cfg_data;
                REG_GAIN_INT:    gain_i_reg  <= cfg_data;
                REG_GAIN_DERIV:  gain_d_reg  <= cfg_data;
                REG_GAIN_DDERIV: gain_dd_reg <= cfg_data;
                REG_MODE:        mode_reg    <= cfg_data[1:0];
                REG_OUTPUT_MAX:  omax_reg    <= cfg_data[W-2:0];
                REG_ERROR_LIMIT: elim_reg    <= cfg_data[W-2:0];
                REG_RATE_LIMIT:  rlim_reg    <= cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    logic [LW-1:0] plim, ilim, dlim, ddlim, elim, rlim;
    assign plim  = LW'((LW'(omax_reg) * LW'(PROP_LIMIT_Q8)) >> 8);
    assign ilim  = LW'((LW'(omax_reg) * LW'(INT_LIMIT_Q8)) >> 8);
    assign dlim  = LW'((LW'(omax_reg) * LW'(DEV_LIMIT_Q8)) >> 8);
    assign ddlim = LW'((LW'(omax_reg) * LW'(DDEV_LIMIT_Q8)) >> 8);
    assign elim  = LW'(elim_reg);
    assign rlim  = LW'(rlim_reg);

    // state
    logic [4:0]           state_reg;
    logic signed [W-1:0]  sp_reg, meas_reg, ext_reg, spd_reg;
    logic signed [SW-1:0] meas_s_reg, err_now_reg, err_prev_reg;
    logic signed [SW-1:0] rate_s_reg, rate_prev_reg, accel_s_reg, x_reg;
    logic signed [W-1:0]  integ_reg, p_reg, d_reg, dd_reg;
    logic signed [W-1:0]  drive_out_reg, p_out_reg, i_out_reg, d_out_reg, dd_out_reg;
    logic                 out_valid_reg;

    // shared multiplier operands
    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] r16, rfr, x_meas, err_int, x_rate;
    logic                 s_acc;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        x_meas = (mode_reg[0]) ? clamp_lim(PW'(ext_reg), elim) : PW'(meas_reg);
        case (state_reg)
            S_M1:
            begin
                mul_a = AW'(x_meas - PW'(meas_s_reg));
                mul_b = BW'(ALPHA_MEAS);
            end
            S_R1:
            begin
                mul_a = AW'(x_reg) - AW'(rate_s_reg);
                mul_b = BW'(ALPHA_RATE);
            end
            S_A1:
            begin
                mul_a = AW'(x_reg) - AW'(accel_s_reg);
                mul_b = BW'(ALPHA_RATE);
            end
            S_P1:
            begin
                mul_a = AW'(err_now_reg);
                mul_b = BW'(gain_p_reg);
            end
            S_I1:
            begin
                mul_a = AW'(err_now_reg);
                mul_b = BW'(gain_i_reg);
            end
            S_D1:
            begin
                mul_a = AW'(rate_s_reg);
                mul_b = BW'(gain_d_reg);
            end
            S_DD1:
            begin
                mul_a = AW'(accel_s_reg);
                mul_b = BW'(gain_dd_reg);
            end
            default: ;
        endcase
    end

    fpid_mul #(.AW(AW), .BW(BW)) u_mul (
        .clk  (clk),
        .en   (state_reg != S_IDLE),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // round half up
    assign r16 = (prod + (PW'(1) <<< (ALPHA_SHIFT - 1))) >>> ALPHA_SHIFT;
    assign rfr = (prod + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign err_int = clamp_lim(PW'(sp_reg) - PW'(meas_s_reg), elim);
    assign x_rate = clamp_lim(mode_reg[1] ? -PW'(spd_reg)
                              : PW'(err_now_reg) - PW'(err_prev_reg), rlim);

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            meas_s_reg    <= '0;
            err_now_reg   <= '0;
            err_prev_reg  <= '0;
            rate_s_reg    <= '0;
            rate_prev_reg <= '0;
            accel_s_reg   <= '0;
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_SUM && (!out_valid_reg || m_tready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (s_acc) state_reg <= S_M1;
                S_M1:   state_reg <= S_M2;
                S_M2:
                begin
                    meas_s_reg <= SW'(PW'(meas_s_reg) + r16);
                    state_reg  <= S_E;
                end
                S_E:
                begin
                    err_prev_reg <= err_now_reg;
                    err_now_reg  <= mode_reg[0] ? meas_s_reg : SW'(err_int);
                    state_reg    <= S_R0;
                end
                S_R0:
                begin
                    rate_prev_reg <= rate_s_reg;
                    state_reg     <= S_R1;
                end
                S_R1:   state_reg <= S_R2;
                S_R2:
                begin
                    rate_s_reg <= SW'(PW'(rate_s_reg) + r16);
                    state_reg  <= S_A0;
                end
                S_A0:   state_reg <= S_A1;
                S_A1:   state_reg <= S_A2;
                S_A2:
                begin
                    accel_s_reg <= SW'(PW'(accel_s_reg) + r16);
                    state_reg   <= S_P1;
                end
                S_P1:   state_reg <= S_P2;
                S_P2:   state_reg <= S_I1;
                S_I1:   state_reg <= S_I2;
                S_I2:
                begin
                    integ_reg <= (gain_i_reg != '0)
                        ? sat_w(clamp_lim(PW'(integ_reg) + rfr, ilim)) : '0;
                    state_reg <= S_D1;
                end
                S_D1:   state_reg <= S_D2;
                S_D2:   state_reg <= S_DD1;
                S_DD1:  state_reg <= S_DD2;
                S_DD2:  state_reg <= S_SUM;
                S_SUM:
                begin
                    if (!out_valid_reg || m_tready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            sp_reg   <= s_tdata[W-1:0];
            meas_reg <= s_tdata[2*W-1:W];
            ext_reg  <= s_tdata[3*W-1:2*W];
            spd_reg  <= s_tdata[4*W-1:3*W];
        end
        // x_reg holds the clamped rate sample, then the rate step
        if (state_reg == S_R0)
            x_reg <= SW'(x_rate);
        if (state_reg == S_A0)
            x_reg <= rate_s_reg - rate_prev_reg;
        if (state_reg == S_P2)
            p_reg <= sat_w(clamp_lim(rfr, plim));
        if (state_reg == S_D2)
            d_reg <= (gain_d_reg != '0) ? sat_w(clamp_lim(rfr, dlim)) : '0;
        if (state_reg == S_DD2)
            dd_reg <= (gain_dd_reg != '0) ? sat_w(clamp_lim(rfr, ddlim)) : '0;
        if (state_reg == S_SUM && (!out_valid_reg || m_tready))
        begin
            drive_out_reg <= sat_w(PW'(p_reg) + PW'(integ_reg) + PW'(d_reg) + PW'(dd_reg));
            p_out_reg     <= p_reg;
            i_out_reg     <= integ_reg;
            d_out_reg     <= d_reg;
            dd_out_reg    <= dd_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_BITS'({dd_out_reg, d_out_reg, i_out_reg, p_out_reg, drive_out_reg});

    `FPID_CHECK_NEXT(a_busy_after_accept, s_acc, !s_tready, "accepted beat did not start sequencer")
    `FPID_CHECK_NOW(a_valid_from_sum, $rose(m_tvalid), $past(state_reg) == S_SUM, "result without sum step")
    `FPID_CHECK_NEXT(a_integ_cleared, state_reg == S_I2 && gain_i_reg == '0, integ_reg == '0, "integral not cleared at zero gain")
endmodule
`default_nettype wire
